[rtl/hcip_pkg.sv]
`default_nettype none

package hcip_pkg;

    localparam int ALPHABET   = 26;
    localparam int LETTER_W   = 5;
    localparam int KEY_COLS   = 4;
    localparam int KEY_ROWS   = 4;
    localparam int ROW_SEL_W  = 2;
    localparam int KEY_ROW_W  = KEY_COLS * LETTER_W;
    localparam int KEY_SIZE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KEY_ROW_W;
    // Four 5-bit by 5-bit products, summed.
    localparam int SUM_W      = 12;
    localparam int SUM_LO_W   = 6;
    localparam int SUM_HI_W   = SUM_W - SUM_LO_W;
    localparam int FOLD_W     = 7;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [KEY_ROW_W-1:0] key_row_t;
    typedef logic [KEY_SIZE_W-1:0] key_size_t;

    localparam letter_t PAD_LETTER = letter_t'(23);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_SIZE = 3'd0,
        REG_KEY_ROW0 = 3'd1,
        REG_KEY_ROW1 = 3'd2,
        REG_KEY_ROW2 = 3'd3,
        REG_KEY_ROW3 = 3'd4
    } cfg_reg_t;

    // Residue of (hi * 2^SUM_LO_W) mod 26 for every upper-half value.
    typedef logic [(1 << SUM_HI_W)-1:0][LETTER_W-1:0] mod_tab_t;

    function automatic mod_tab_t build_mod_hi();
        mod_tab_t t;
        for (int i = 0; i < (1 << SUM_HI_W); i++)
        begin
            t[i] = letter_t'((i * (1 << SUM_LO_W)) % ALPHABET);
        end
        return t;
    endfunction

    // Final reduction of a folded value below 4 * 26.
    function automatic letter_t mod26_small(logic [FOLD_W-1:0] v);
        logic [FOLD_W-1:0] r;
        if (v >= FOLD_W'(3 * ALPHABET))
            r = v - FOLD_W'(3 * ALPHABET);
        else if (v >= FOLD_W'(2 * ALPHABET))
            r = v - FOLD_W'(2 * ALPHABET);
        else if (v >= FOLD_W'(ALPHABET))
            r = v - FOLD_W'(ALPHABET);
        else
            r = v;
        return r[LETTER_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/hcip_if.sv]
`default_nettype none

interface hcip_in_if;
    logic                     valid;
    logic                     ready;
    logic [4:0]               plain_letter;
    logic                     end_of_message;

    modport source (output valid, output plain_letter, output end_of_message, input ready);
    modport sink   (input valid, input plain_letter, input end_of_message, output ready);
endinterface

interface hcip_out_if;
    logic                     valid;
    logic                     ready;
    logic [4:0]               cipher_letter;
    logic                     last_in_block;
    logic                     last_in_message;

    modport source (output valid, output cipher_letter, output last_in_block,
                    output last_in_message, input ready);
    modport sink   (input valid, input cipher_letter, input last_in_block,
                    input last_in_message, output ready);
endinterface

interface hcip_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               index;
    logic [19:0]              data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/hcip_row_unit.sv]
`default_nettype none

// One cipher letter: key row dotted with the block, mod 26.
module hcip_row_unit #(
    parameter int MAX_N = 4
) (
    input  wire hcip_pkg::key_row_t               key_row,
    input  wire hcip_pkg::letter_t                letters [MAX_N],
    input  wire logic [$clog2(MAX_N+1)-1:0]       n_eff,
    output hcip_pkg::letter_t                     cipher
);
    import hcip_pkg::*;

    localparam int CNT_W = $clog2(MAX_N + 1);
    localparam mod_tab_t MOD_HI = build_mod_hi();

    logic [SUM_W-1:0]  sum;
    logic [FOLD_W-1:0] folded;

    always_comb
    begin
        sum = '0;
        for (int j = 0; j < MAX_N; j++)
        begin
            if (CNT_W'(j) < n_eff)
                sum = sum + SUM_W'(key_row[j*LETTER_W +: LETTER_W]) * SUM_W'(letters[j]);
        end
    end

    assign folded = FOLD_W'(MOD_HI[sum[SUM_W-1:SUM_LO_W]]) + FOLD_W'(sum[SUM_LO_W-1:0]);
    assign cipher = mod26_small(folded);

endmodule

`default_nettype wire

[rtl/hill_cipher_encrypt.sv]
`default_nettype none

// Hill cipher encryptor, 26-letter alphabet.
//
// cfg    : register writes, always ready. Index 0 is key_size (n, 0 acts as 1,
//          above MAX_N acts as MAX_N; a write drops any partial block), 1..4
//          are key rows 0..3, four 5-bit entries each, column 0 in low bits.
//          Write only while no letters are in flight.
// plain  : one letter per transaction; end_of_message pads the open block
//          with x and closes it.
// cipher : n letters per closed block, last_in_block on the n-th,
//          last_in_message also set when the block closed the message.
//
// Path: a closing letter fills the block register; each cipher letter then
// passes the output register. Throughput: one letter per cycle in each
// direction while nothing stalls; blocks go one row at a time through the
// single dot-product/mod-26 unit, so a padded short block holds off the
// letter closing the next block until the previous block has drained.
// Reset: key_size 2, key rows 0, empty block, nothing pending.
// A stalled receiver holds the output register; the block register behind it
// then fills and plain stalls once the next block would close.
module hill_cipher_encrypt #(
    parameter int MAX_N = 4
) (
    input  wire        clk,
    input  wire        rst_n,
    hcip_cfg_if.sink   cfg,
    hcip_in_if.sink    plain,
    hcip_out_if.source cipher
);
    import hcip_pkg::*;

    localparam int CNT_W = $clog2(MAX_N + 1);
    localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    // configuration
    key_size_t          key_size_reg;
    key_row_t           key_rows_reg [KEY_ROWS];
    logic [CNT_W-1:0]   n_eff;

    // gather stage
    letter_t            buf_reg [MAX_N];
    logic [CNT_W-1:0]   fill_count_reg;
    logic [CNT_W-1:0]   fill_eff;
    logic               completes;
    logic               accept;

    // held block, read out one row per cycle while the output register is free
    letter_t            blk_letters_reg [MAX_N];
    letter_t            blk_letters_next [MAX_N];
    logic               blk_valid_reg;
    logic               blk_eom_reg;
    logic [IDX_W-1:0]   row_reg;
    logic               last_row;
    logic               blk_free;
    logic               issue;
    letter_t            row_cipher;

    // output register
    logic               out_valid_reg;
    letter_t            out_letter_reg;
    logic               out_last_blk_reg;
    logic               out_last_msg_reg;
    logic               out_free;

    always_comb
    begin
        if (key_size_reg == '0)
            n_eff = CNT_W'(1);
        else if (key_size_reg > KEY_SIZE_W'(MAX_N))
            n_eff = CNT_W'(MAX_N);
        else
            n_eff = CNT_W'(key_size_reg);
    end

    assign cfg.ready = 1'b1;

    // ---- gather ----
    assign fill_eff  = (fill_count_reg >= n_eff) ? '0 : fill_count_reg;
    assign completes = (fill_eff + CNT_W'(1) == n_eff) || plain.end_of_message;

    assign out_free = !out_valid_reg || cipher.ready;
    assign issue    = blk_valid_reg && out_free;
    assign last_row = (CNT_W'(row_reg) + CNT_W'(1) == n_eff);
    assign blk_free = !blk_valid_reg || (issue && last_row);

    // Letters that only extend the block never need the block register.
    assign plain.ready = blk_free || !completes;
    assign accept      = plain.valid && plain.ready;

    // Closed block: buffered letters, the new one, then x padding.
    always_comb
    begin
        for (int j = 0; j < MAX_N; j++)
        begin
            if (CNT_W'(j) < fill_eff)
                blk_letters_next[j] = buf_reg[j];
            else if (CNT_W'(j) == fill_eff)
                blk_letters_next[j] = letter_t'(plain.plain_letter);
            else
                blk_letters_next[j] = PAD_LETTER;
        end
    end

    // ---- one row of the key per cycle while the output register is free ----
    hcip_row_unit #(
        .MAX_N (MAX_N)
    ) u_row (
        .key_row (key_rows_reg[ROW_SEL_W'(row_reg)]),
        .letters (blk_letters_reg),
        .n_eff   (n_eff),
        .cipher  (row_cipher)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg   <= KEY_SIZE_W'(2);
            for (int r = 0; r < KEY_ROWS; r++)
            begin
                key_rows_reg[r] <= '0;
            end
            fill_count_reg <= '0;
            blk_valid_reg  <= 1'b0;
            blk_eom_reg    <= 1'b0;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_KEY_SIZE: key_size_reg    <= cfg.data[KEY_SIZE_W-1:0];
                    REG_KEY_ROW0: key_rows_reg[0] <= cfg.data;
                    REG_KEY_ROW1: key_rows_reg[1] <= cfg.data;
                    REG_KEY_ROW2: key_rows_reg[2] <= cfg.data;
                    REG_KEY_ROW3: key_rows_reg[3] <= cfg.data;
                    default: ;
                endcase
            end

            // a key_size write drops the partial block
            if (accept)
                fill_count_reg <= completes ? '0 : fill_eff + CNT_W'(1);
            else if (cfg.valid && cfg.ready && (cfg.index == REG_KEY_SIZE))
                fill_count_reg <= '0;

            if (issue)
            begin
                if (last_row)
                    row_reg <= '0;
                else
                    row_reg <= row_reg + IDX_W'(1);
            end

            // a new block may land as the old one leaves
            if (accept && completes)
            begin
                blk_valid_reg <= 1'b1;
                blk_eom_reg   <= plain.end_of_message;
            end
            else if (issue && last_row)
            begin
                blk_valid_reg <= 1'b0;
            end

            if (issue)
                out_valid_reg <= 1'b1;
            else if (cipher.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept && !completes)
            buf_reg[IDX_W'(fill_eff)] <= letter_t'(plain.plain_letter);
        if (accept && completes)
            blk_letters_reg <= blk_letters_next;
        if (issue)
        begin
            out_letter_reg   <= row_cipher;
            out_last_blk_reg <= last_row;
            out_last_msg_reg <= last_row && blk_eom_reg;
        end
    end

    assign cipher.valid           = out_valid_reg;
    assign cipher.cipher_letter   = out_letter_reg;
    assign cipher.last_in_block   = out_last_blk_reg;
    assign cipher.last_in_message = out_last_msg_reg;

    // ---- checks ----
    a_fill_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg < n_eff)
        else $error("fill count reached block length");

    a_row_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        blk_valid_reg |-> (CNT_W'(row_reg) < n_eff))
        else $error("row index beyond block length");

    a_blk_drains_fully: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(blk_valid_reg) |-> $past(issue && last_row))
        else $error("block dropped before its last row");

    a_cipher_in_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_letter_reg < letter_t'(ALPHABET)))
        else $error("cipher letter outside alphabet");

endmodule

`default_nettype wire
